### hw/rtl/delivery_rate_sampler_unit_assert.svh
// assertion macros used by the checker file
`ifndef DELIVERY_RATE_SAMPLER_UNIT_ASSERT_SVH
`define DELIVERY_RATE_SAMPLER_UNIT_ASSERT_SVH

// same-cycle implication
`define DRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("drs assertion failed");

// next-cycle implication
`define DRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("drs assertion failed");

`endif

### hw/rtl/drs_pkg.sv
// types, constants and helpers of the delivery rate sampler
package drs_pkg;

  localparam int unsigned SLOTS_DEF   = 64;
  localparam int unsigned IN_TDATA_W  = 152;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 128;
  localparam int unsigned OUT_TUSER_W = 3;
  localparam int unsigned ALU_W       = 65;
  localparam int unsigned MUL_STEPS   = 4;
  localparam int unsigned DIV_STEPS   = 64;
  localparam int unsigned MUL_TOP_SHIFT = 20;

  localparam logic [63:0] USEC_PER_SEC = 64'd1000000;
  localparam logic [63:0] BYTES_LIMIT  = 64'hFFFF_FFFF_FFFF_FFFF / USEC_PER_SEC;

  typedef enum logic [1:0] {
    REQ_SENT  = 2'd0,
    REQ_ACKED = 2'd1,
    REQ_LOST  = 2'd2,
    REQ_MARK  = 2'd3
  } req_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] number;
    logic [63:0] sent_time;
    logic [15:0] size;
    logic [63:0] acked_at_send;
    logic [63:0] last_ack_at_send;
    logic        lim_at_send;
  } rec_t;

  typedef struct packed {
    logic [ALU_W-1:0] op_a;
    logic [ALU_W-1:0] op_b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] value;
    logic             borrow;
    logic             zero;
  } alu_res_t;

  // 10^6 = 2^20 - 2^16 + 2^14 + 2^9 + 2^6
  function automatic logic [4:0] mul_shift(input logic [1:0] step);
    logic [4:0] sh;
    case (step)
      2'd0:    sh = 5'd16;
      2'd1:    sh = 5'd14;
      2'd2:    sh = 5'd9;
      default: sh = 5'd6;
    endcase
    return sh;
  endfunction

endpackage

### hw/rtl/drs_ram.sv
// generic single-port ram with registered read
module drs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                           wdata,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hw/rtl/drs_alu.sv
// shared add / subtract unit with borrow and zero flags
module drs_alu (
  input  drs_pkg::alu_req_t req,
  output drs_pkg::alu_res_t res
);

  logic [drs_pkg::ALU_W:0] sum;

  assign sum = {1'b0, req.op_a} + {1'b0, (req.sub ? ~req.op_b : req.op_b)}
             + (drs_pkg::ALU_W + 1)'(req.sub);

  assign res.value  = sum[drs_pkg::ALU_W-1:0];
  assign res.borrow = req.sub & ~sum[drs_pkg::ALU_W];
  assign res.zero   = (sum[drs_pkg::ALU_W-1:0] == '0);

endmodule

### hw/rtl/delivery_rate_sampler_unit.sv
// delivery rate sampler: record table, sequencer and shared arithmetic unit
//
// input channel in_*: one packet event per transaction (send, ack, loss or
// mark app limited); in_tuser carries the event kind, in_tdata its fields.
// result channel out_*: exactly one result per event; ack_taken flags an ack
// that matched a live record, with rtt, app-limited flag and delivery rate.
// path to out_tvalid: send, loss, mark and acks without a matching record
// go from lookup to the result; an ack with a stale time ends after the span
// check, and one whose rate would overflow ends there with a zero rate; a taken
// ack gets its rate from the 64-step restoring division on the shared 65-bit
// add/subtract unit, after 6 single steps and a 4-step multiply by 10^6.
// flow: one event in flight; in_tready is high only when idle, so a new
// event is taken only once the last one's result is in the output register.
// reset: a clearing pass writes every record invalid, with in_tready low;
// totals and flags take their reset values.
// stall: a finished result waits in the output register; the next event is
// still taken, and its result waits until the earlier one is delivered,
// with in_tready low meanwhile.
module delivery_rate_sampler_unit #(
  parameter int unsigned SLOTS = drs_pkg::SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // slot, seq_num, byte_len, time_us, zero pad
  input  logic [drs_pkg::IN_TDATA_W-1:0]     in_tdata,
  // req_type
  input  logic [drs_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // bandwidth_Bps (bytes per second), rtt_us
  output logic [drs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // ack_taken, sample_ok, sent_limited
  output logic [drs_pkg::OUT_TUSER_W-1:0]    out_tuser
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned REC_W = $bits(drs_pkg::rec_t);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LOOK, S_SPAN, S_RTT, S_ACC, S_LIM, S_BYTES, S_OVF,
    S_MUL, S_DIV, S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [63:0]       acked_total_r, acked_total_nxt;
  logic [63:0]       last_ack_r, last_ack_nxt;
  logic [63:0]       last_sent_r, last_sent_nxt;
  logic [63:0]       limited_until_r, limited_until_nxt;
  logic              limited_flag_r, limited_flag_nxt;

  drs_pkg::req_t     kind_r, kind_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              in_range_r, in_range_nxt;
  logic [63:0]       pnum_r, pnum_nxt;
  logic [15:0]       size_r, size_nxt;
  logic [63:0]       time_r, time_nxt;
  logic              taken_r, taken_nxt;
  logic              clr_lim_r, clr_lim_nxt;
  logic [63:0]       span_r, span_nxt;
  logic [63:0]       rtt_r, rtt_nxt;
  logic [63:0]       acked_new_r, acked_new_nxt;
  logic [63:0]       bytes_r, bytes_nxt;
  logic [drs_pkg::ALU_W-1:0] acc_r, acc_nxt;
  logic [63:0]       quot_r, quot_nxt;
  logic [drs_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [drs_pkg::OUT_TUSER_W-1:0] out_tuser_r, out_tuser_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  drs_pkg::rec_t     ram_wdata;
  logic [REC_W-1:0]  ram_rdata;
  drs_pkg::rec_t     rd;
  drs_pkg::alu_req_t alu_req;
  drs_pkg::alu_res_t alu_res;
  logic [IDX_W-1:0]  in_idx;
  logic              in_in_range;
  logic [drs_pkg::ALU_W-1:0] div_a;

  assign rd          = ram_rdata;
  assign in_idx      = IDX_W'(in_tdata[5:0]);
  assign in_in_range = (32'(in_tdata[5:0]) < SLOTS);
  assign div_a       = {acc_r[63:0], quot_r[63]};

  drs_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOTS)
  ) u_drs_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  drs_alu u_drs_alu (
    .req (alu_req),
    .res (alu_res)
  );

  always_comb begin
    state_nxt         = state_r;
    clr_cnt_nxt       = clr_cnt_r;
    cnt_nxt           = cnt_r;
    out_tvalid_nxt    = out_tvalid_r & ~out_tready;
    acked_total_nxt   = acked_total_r;
    last_ack_nxt      = last_ack_r;
    last_sent_nxt     = last_sent_r;
    limited_until_nxt = limited_until_r;
    limited_flag_nxt  = limited_flag_r;
    kind_nxt          = kind_r;
    idx_nxt           = idx_r;
    in_range_nxt      = in_range_r;
    pnum_nxt          = pnum_r;
    size_nxt          = size_r;
    time_nxt          = time_r;
    taken_nxt         = taken_r;
    clr_lim_nxt       = clr_lim_r;
    span_nxt          = span_r;
    rtt_nxt           = rtt_r;
    acked_new_nxt     = acked_new_r;
    bytes_nxt         = bytes_r;
    acc_nxt           = acc_r;
    quot_nxt          = quot_r;
    out_tdata_nxt     = out_tdata_r;
    out_tuser_nxt     = out_tuser_r;
    ram_we            = 1'b0;
    ram_addr          = idx_r;
    ram_wdata         = '0;
    alu_req           = '0;

    case (state_r)
      S_CLR: begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt_r;
        if (clr_cnt_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        ram_addr = in_idx;
        if (in_tvalid) begin
          kind_nxt     = drs_pkg::req_t'(in_tuser);
          idx_nxt      = in_idx;
          in_range_nxt = in_in_range;
          pnum_nxt     = in_tdata[69:6];
          size_nxt     = in_tdata[85:70];
          time_nxt     = in_tdata[149:86];
          taken_nxt    = 1'b0;
          state_nxt    = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_DONE;
        case (kind_r)
          drs_pkg::REQ_MARK: begin
            limited_flag_nxt  = 1'b1;
            limited_until_nxt = last_sent_r;
          end
          drs_pkg::REQ_SENT: begin
            if (in_range_r && pnum_r != '0 && size_r != '0) begin
              ram_we                     = 1'b1;
              ram_wdata.valid            = 1'b1;
              ram_wdata.number           = pnum_r;
              ram_wdata.sent_time        = time_r;
              ram_wdata.size             = size_r;
              ram_wdata.acked_at_send    = acked_total_r;
              ram_wdata.last_ack_at_send = last_ack_r;
              ram_wdata.lim_at_send      = limited_flag_r;
              last_sent_nxt              = pnum_r;
            end
          end
          drs_pkg::REQ_LOST: begin
            ram_we = in_range_r;
          end
          drs_pkg::REQ_ACKED: begin
            if (in_range_r && rd.valid && rd.number == pnum_r) begin
              state_nxt = S_SPAN;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SPAN: begin
        alu_req.op_a = {1'b0, time_r};
        alu_req.op_b = {1'b0, rd.last_ack_at_send};
        alu_req.sub  = 1'b1;
        if (alu_res.borrow || alu_res.zero) begin
          state_nxt = S_DONE;
        end else begin
          span_nxt  = alu_res.value[63:0];
          taken_nxt = 1'b1;
          state_nxt = S_RTT;
        end
      end
      S_RTT: begin
        alu_req.op_a = {1'b0, time_r};
        alu_req.op_b = {1'b0, rd.sent_time};
        alu_req.sub  = 1'b1;
        rtt_nxt      = alu_res.value[63:0];
        state_nxt    = S_ACC;
      end
      S_ACC: begin
        alu_req.op_a  = {1'b0, acked_total_r};
        alu_req.op_b  = drs_pkg::ALU_W'(rd.size);
        acked_new_nxt = alu_res.value[63:0];
        state_nxt     = S_LIM;
      end
      S_LIM: begin
        alu_req.op_a = {1'b0, limited_until_r};
        alu_req.op_b = {1'b0, pnum_r};
        alu_req.sub  = 1'b1;
        clr_lim_nxt  = limited_flag_r & alu_res.borrow;
        state_nxt    = S_BYTES;
      end
      S_BYTES: begin
        alu_req.op_a = {1'b0, acked_new_r};
        alu_req.op_b = {1'b0, rd.acked_at_send};
        alu_req.sub  = 1'b1;
        bytes_nxt    = alu_res.value[63:0];
        state_nxt    = S_OVF;
      end
      S_OVF: begin
        alu_req.op_a = {1'b0, drs_pkg::BYTES_LIMIT};
        alu_req.op_b = {1'b0, bytes_r};
        alu_req.sub  = 1'b1;
        if (alu_res.borrow) begin
          quot_nxt  = '0;
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        alu_req.op_a = (cnt_r == '0)
                     ? (drs_pkg::ALU_W'(bytes_r) << drs_pkg::MUL_TOP_SHIFT) : acc_r;
        alu_req.op_b = drs_pkg::ALU_W'(bytes_r) << drs_pkg::mul_shift(cnt_r[1:0]);
        alu_req.sub  = (cnt_r == '0);
        acc_nxt      = alu_res.value;
        if (cnt_r == 6'(drs_pkg::MUL_STEPS - 1)) begin
          quot_nxt  = alu_res.value[63:0];
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIV: begin
        alu_req.op_a = div_a;
        alu_req.op_b = {1'b0, span_r};
        alu_req.sub  = 1'b1;
        acc_nxt      = alu_res.borrow ? div_a : alu_res.value;
        quot_nxt     = {quot_r[62:0], ~alu_res.borrow};
        if (cnt_r == 6'(drs_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = taken_r ? {rtt_r, quot_r} : '0;
          out_tuser_nxt  = {taken_r & rd.lim_at_send, taken_r & (rtt_r != '0), taken_r};
          if (taken_r) begin
            acked_total_nxt = acked_new_r;
            last_ack_nxt    = time_r;
            if (clr_lim_r) begin
              limited_flag_nxt = 1'b0;
            end
            ram_we = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    idx_r       <= idx_nxt;
    in_range_r  <= in_range_nxt;
    pnum_r      <= pnum_nxt;
    size_r      <= size_nxt;
    time_r      <= time_nxt;
    taken_r     <= taken_nxt;
    clr_lim_r   <= clr_lim_nxt;
    span_r      <= span_nxt;
    rtt_r       <= rtt_nxt;
    acked_new_r <= acked_new_nxt;
    bytes_r     <= bytes_nxt;
    acc_r       <= acc_nxt;
    quot_r      <= quot_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    if (!rst_n) begin
      state_r         <= S_CLR;
      clr_cnt_r       <= '0;
      cnt_r           <= '0;
      out_tvalid_r    <= 1'b0;
      acked_total_r   <= '0;
      last_ack_r      <= '0;
      last_sent_r     <= '0;
      limited_until_r <= '0;
      limited_flag_r  <= 1'b1;
    end else begin
      state_r         <= state_nxt;
      clr_cnt_r       <= clr_cnt_nxt;
      cnt_r           <= cnt_nxt;
      out_tvalid_r    <= out_tvalid_nxt;
      acked_total_r   <= acked_total_nxt;
      last_ack_r      <= last_ack_nxt;
      last_sent_r     <= last_sent_nxt;
      limited_until_r <= limited_until_nxt;
      limited_flag_r  <= limited_flag_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

### hw/rtl/drs_checker.sv
// port-level checks of the delivery rate sampler, bound to the top level
`include "delivery_rate_sampler_unit_assert.svh"

module drs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [drs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [drs_pkg::OUT_TUSER_W-1:0] out_tuser
);

  // stalled result holds
  `DRS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  // one event in flight
  `DRS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // sample_ok only on a taken ack
  `DRS_ASSERT_NOW(a_ok_needs_taken, clk, rst_n, out_tvalid && out_tuser[1], out_tuser[0])
  // untaken transaction carries zeros
  `DRS_ASSERT_NOW(a_zero_untaken, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata == '0 && !out_tuser[2])
  // sample_ok tracks nonzero rtt
  `DRS_ASSERT_NOW(a_ok_rtt, clk, rst_n, out_tvalid && out_tuser[0], out_tuser[1] == (out_tdata[127:64] != '0))

endmodule

bind delivery_rate_sampler_unit drs_checker u_drs_checker (.*);
